@@ src/ofeh_pkg.sv @@
// Shared types and constants for the opcode and function event histogram.
package ofeh_pkg;

	localparam int unsigned OUT_WIDTH = 32;
	localparam logic [7:0] NO_FUNC_INDEX = 8'd255;
	localparam logic [7:0] NO_INSTR_INDEX = 8'd0;

	typedef enum logic [1:0] {
		OP_COUNT_INSTR = 2'd0,
		OP_COUNT_FUNC  = 2'd1,
		OP_READ_INSTR  = 2'd2,
		OP_READ_FUNC   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] event_id;
	} cmd_t;

	typedef struct packed {
		logic                 accepted;
		logic [OUT_WIDTH-1:0] bin_count;
		logic [OUT_WIDTH-1:0] table_total;
		logic [7:0]           most_used_index;
		logic [OUT_WIDTH-1:0] most_used_count;
		logic                 most_used_found;
	} result_t;

	// Bit 0 of the opcode selects the function table, bit 1 marks a read.
	function automatic logic op_is_func(input logic [1:0] op);
		return (op == OP_COUNT_FUNC) || (op == OP_READ_FUNC);
	endfunction

	function automatic logic op_is_count(input logic [1:0] op);
		return (op == OP_COUNT_INSTR) || (op == OP_COUNT_FUNC);
	endfunction

endpackage

@@ src/opcode_and_function_event_histogram.sv @@
// Top level: two saturating event histograms with running totals and peak bins.
//
// Usage:
//   Command channel: cmd (opcode, event_id) is taken at a clock edge where
//   start is high and busy is low. Opcodes count or read a bin of the
//   instruction table or of the function table.
//   Result channel: done strobes for one cycle with result valid; the receiver
//   cannot hold it off, so it must take it in that cycle. Config: cfg_we loads
//   cfg_wdata into count_enable; user must do so only while idle, unchecked.
// Timing:
//   busy is high in the cycle after a command is taken; done is high in
//   the cycle after that. A new command can be taken while done is high, but
//   not while busy. Busy covers the read-modify-write of the addressed bin in
//   its RAM (registered read, then update and write back in the busy cycle).
//   Running total and most-used bin are kept in registers and updated with
//   each increment; no table scan.
// Reset:
//   arst_n clears count_enable, totals and peaks, and the per-entry valid bits
//   so every bin reads zero at once; the block is ready right after reset.
module opcode_and_function_event_histogram #(
	parameter int unsigned OPCODE_BINS   = 64,
	parameter int unsigned FUNCTION_BINS = 16,
	parameter int unsigned COUNT_WIDTH   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ofeh_pkg::cmd_t    cmd,
	output logic              done,
	output ofeh_pkg::result_t result,
	input  logic              cfg_we,
	input  logic              cfg_wdata
);
	import ofeh_pkg::*;

	localparam int unsigned IW  = (OPCODE_BINS > 1) ? $clog2(OPCODE_BINS) : 1;
	localparam int unsigned FW  = (FUNCTION_BINS > 1) ? $clog2(FUNCTION_BINS) : 1;
	localparam int unsigned EXT = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
		logic [EXT-1:0] w;
		w = EXT'(v);
		return w[OUT_WIDTH-1:0];
	endfunction

	// control and configuration
	logic count_enable_q;
	logic valid_s1;

	// stage 1 payload
	logic [1:0] op_s1;
	logic [7:0] id_s1;
	logic       in_range_s1;
	logic       bin_valid_s1;

	// per-entry valid bits: an entry never written reads as zero
	logic [OPCODE_BINS-1:0]   instr_valid_q;
	logic [FUNCTION_BINS-1:0] func_valid_q;

	// running totals and peaks
	logic [COUNT_WIDTH-1:0] instr_sum_q, func_sum_q;
	logic [COUNT_WIDTH-1:0] instr_peak_count_q, func_peak_count_q;
	logic [IW-1:0]          instr_peak_idx_q;
	logic [FW-1:0]          func_peak_idx_q;

	// result register
	logic    done_q;
	result_t result_q;

	// accept side
	logic          accept;
	logic          acc_is_func;
	logic          acc_in_range;
	logic [IW-1:0] acc_iidx;
	logic [FW-1:0] acc_fidx;

	// RAM ports
	logic                   instr_we, func_we;
	logic [COUNT_WIDTH-1:0] instr_rdata, func_rdata;
	logic [IW-1:0]          iidx_s1;
	logic [FW-1:0]          fidx_s1;

	// stage 1 datapath
	logic                   is_func, is_count;
	logic                   inc_ok;
	logic [COUNT_WIDTH-1:0] old_bin, new_bin, bin_after;
	logic [COUNT_WIDTH-1:0] sum_cur, sum_after;
	logic [COUNT_WIDTH-1:0] peak_cur, peak_after;
	logic [7:0]             peak_idx_cur, peak_idx_after;
	logic                   found;

	assign accept       = start && !busy;
	assign acc_is_func  = op_is_func(cmd.opcode);
	assign acc_in_range = acc_is_func ? ({1'b0, cmd.event_id} < 9'(FUNCTION_BINS))
	                                  : ({1'b0, cmd.event_id} < 9'(OPCODE_BINS));
	assign acc_iidx     = acc_in_range ? cmd.event_id[IW-1:0] : '0;
	assign acc_fidx     = acc_in_range ? cmd.event_id[FW-1:0] : '0;
	assign iidx_s1      = id_s1[IW-1:0];
	assign fidx_s1      = id_s1[FW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_enable_q <= 1'b0;
			valid_s1       <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_enable_q <= cfg_wdata;
			end
			valid_s1 <= accept;
			done_q   <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= cmd.opcode;
			id_s1        <= acc_in_range ? cmd.event_id : 8'd0;
			in_range_s1  <= acc_in_range;
			bin_valid_s1 <= acc_is_func ? func_valid_q[acc_fidx] : instr_valid_q[acc_iidx];
		end
	end

	ofeh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (OPCODE_BINS)
	) u_instr_ram (
		.clk   (clk),
		.we    (instr_we),
		.waddr (iidx_s1),
		.wdata (new_bin),
		.re    (accept),
		.raddr (acc_iidx),
		.rdata (instr_rdata)
	);

	ofeh_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (FUNCTION_BINS)
	) u_func_ram (
		.clk   (clk),
		.we    (func_we),
		.waddr (fidx_s1),
		.wdata (new_bin),
		.re    (accept),
		.raddr (acc_fidx),
		.rdata (func_rdata)
	);

	always_comb begin
		is_func  = op_is_func(op_s1);
		is_count = op_is_count(op_s1);
		old_bin  = bin_valid_s1 ? (is_func ? func_rdata : instr_rdata) : '0;
		new_bin  = old_bin + COUNT_WIDTH'(1);
		// a saturated bin stays put and leaves total and peak alone
		inc_ok   = valid_s1 && in_range_s1 && is_count && count_enable_q &&
		           (old_bin != COUNT_MAX);
		bin_after = inc_ok ? new_bin : old_bin;

		sum_cur      = is_func ? func_sum_q : instr_sum_q;
		peak_cur     = is_func ? func_peak_count_q : instr_peak_count_q;
		peak_idx_cur = is_func ? 8'(func_peak_idx_q) : 8'(instr_peak_idx_q);

		sum_after      = sum_cur;
		peak_after     = peak_cur;
		peak_idx_after = peak_idx_cur;
		if (inc_ok) begin
			if (sum_cur != COUNT_MAX) begin
				sum_after = sum_cur + COUNT_WIDTH'(1);
			end
			if (new_bin > peak_cur) begin
				peak_after     = new_bin;
				peak_idx_after = id_s1;
			end else if (new_bin == peak_cur && id_s1 < peak_idx_cur) begin
				peak_idx_after = id_s1;
			end
		end
		found = peak_after != '0;

		instr_we = inc_ok && !is_func;
		func_we  = inc_ok && is_func;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			instr_valid_q      <= '0;
			func_valid_q       <= '0;
			instr_sum_q        <= '0;
			func_sum_q         <= '0;
			instr_peak_count_q <= '0;
			func_peak_count_q  <= '0;
			instr_peak_idx_q   <= '0;
			func_peak_idx_q    <= '0;
		end else begin
			if (instr_we) begin
				instr_valid_q[iidx_s1] <= 1'b1;
				instr_sum_q            <= sum_after;
				instr_peak_count_q     <= peak_after;
				instr_peak_idx_q       <= peak_idx_after[IW-1:0];
			end
			if (func_we) begin
				func_valid_q[fidx_s1] <= 1'b1;
				func_sum_q            <= sum_after;
				func_peak_count_q     <= peak_after;
				func_peak_idx_q       <= peak_idx_after[FW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.accepted        <= in_range_s1 && (!is_count || count_enable_q);
			result_q.bin_count       <= in_range_s1 ? to_out(bin_after) : '0;
			result_q.table_total     <= to_out(sum_after);
			result_q.most_used_count <= to_out(peak_after);
			result_q.most_used_found <= found;
			if (found) begin
				result_q.most_used_index <= peak_idx_after;
			end else begin
				result_q.most_used_index <= is_func ? NO_FUNC_INDEX : NO_INSTR_INDEX;
			end
		end
	end

	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;
endmodule

@@ src/ofeh_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ofeh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ src/ofeh_checker.sv @@
// Port-level checker for the event histogram, bound to the top level.
module ofeh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input ofeh_pkg::cmd_t    cmd,
	input logic              done,
	input ofeh_pkg::result_t result
);
	import ofeh_pkg::*;

	// every taken command yields exactly one busy cycle, then its result
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 done)
		else $error("taken item did not produce a result two cycles later");

	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without an item in flight");

	// an empty table has no total and reports no peak count
	a_empty_table: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.most_used_found) |->
			(result.most_used_count == '0 && result.table_total == '0))
		else $error("empty table reports nonzero total or peak");

	a_no_bin_on_reject_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.accepted && result.bin_count != '0) |->
			$past(op_is_count(cmd.opcode), 2))
		else $error("rejected read returned a nonzero bin");
endmodule

bind opcode_and_function_event_histogram ofeh_checker u_ofeh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.cmd       (cmd),
	.done      (done),
	.result    (result)
);

@@ bench/opcode_and_function_event_histogram_tb.sv @@
// Self-checking testbench for the opcode and function event histogram.
module opcode_and_function_event_histogram_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ofeh_pkg::*;

	localparam int unsigned INSTR_BINS = 64;
	localparam int unsigned FUNC_BINS  = 16;
	localparam int unsigned PHASE_ITEMS = 360;

	typedef struct {
		bit      is_cfg;
		bit      cfg_val;
		cmd_t    c;
		bit      pinned;
		result_t want;
	} row_t;

	typedef struct {
		bit      valid;
		result_t want;
	} typed_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    done;
	result_t result;
	logic    cfg_we;
	logic    cfg_wdata;

	// histogram shadow state
	bit [31:0] instr_bins [INSTR_BINS];
	bit [31:0] func_bins [FUNC_BINS];
	bit [31:0] instr_sum, func_sum, instr_peak, func_peak;
	bit [7:0]  instr_peak_idx, func_peak_idx;
	bit        count_on;

	typed_t  typed_results[$];
	result_t pending_results[$];
	row_t    script[$];
	int      errors = 0;

	always #2ns clk = ~clk;

	opcode_and_function_event_histogram #(
		.OPCODE_BINS(INSTR_BINS),
		.FUNCTION_BINS(FUNC_BINS),
		.COUNT_WIDTH(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	function automatic result_t histogram_apply(cmd_t c);
		result_t     r;
		logic        func_sel;
		logic        is_count;
		int unsigned id;
		int unsigned size;
		bit [31:0]   v, sum, peak;
		bit [7:0]    pidx;
		func_sel = (c.opcode == OP_COUNT_FUNC) || (c.opcode == OP_READ_FUNC);
		is_count = (c.opcode == OP_COUNT_INSTR) || (c.opcode == OP_COUNT_FUNC);
		id = c.event_id;
		size = func_sel ? FUNC_BINS : INSTR_BINS;
		sum = func_sel ? func_sum : instr_sum;
		peak = func_sel ? func_peak : instr_peak;
		pidx = func_sel ? func_peak_idx : instr_peak_idx;
		r = '0;
		if (id < size) begin
			v = func_sel ? func_bins[id] : instr_bins[id];
			if (!is_count) begin
				r.accepted = 1'b1;
			end else if (count_on) begin
				r.accepted = 1'b1;
				if (v != '1) begin
					v = v + 1;
					if (sum != '1) sum = sum + 1;
					if (v > peak) begin
						peak = v;
						pidx = id[7:0];
					end else if (v == peak && id < pidx) begin
						pidx = id[7:0];
					end
					if (func_sel) func_bins[id] = v;
					else instr_bins[id] = v;
				end
			end
			r.bin_count = v;
		end
		if (func_sel) begin
			func_sum = sum;
			func_peak = peak;
			func_peak_idx = pidx;
		end else begin
			instr_sum = sum;
			instr_peak = peak;
			instr_peak_idx = pidx;
		end
		r.table_total = sum;
		r.most_used_count = peak;
		r.most_used_found = (peak != 0);
		// an empty table has no peak bin; each table reports its own marker
		if (peak != 0) r.most_used_index = pidx;
		else r.most_used_index = func_sel ? NO_FUNC_INDEX : NO_INSTR_INDEX;
		return r;
	endfunction

	task automatic compare_result(result_t want, result_t got);
		if (got.accepted !== want.accepted) begin
			$display("%0t: accepted expected %0d, got %0d", $time, want.accepted, got.accepted);
			errors++;
		end
		if (got.bin_count !== want.bin_count) begin
			$display("%0t: bin_count expected %0d, got %0d", $time, want.bin_count,
				got.bin_count);
			errors++;
		end
		if (got.table_total !== want.table_total) begin
			$display("%0t: table_total expected %0d, got %0d", $time, want.table_total,
				got.table_total);
			errors++;
		end
		if (got.most_used_index !== want.most_used_index) begin
			$display("%0t: most_used_index expected %0d, got %0d", $time,
				want.most_used_index, got.most_used_index);
			errors++;
		end
		if (got.most_used_count !== want.most_used_count) begin
			$display("%0t: most_used_count expected %0d, got %0d", $time,
				want.most_used_count, got.most_used_count);
			errors++;
		end
		if (got.most_used_found !== want.most_used_found) begin
			$display("%0t: most_used_found expected %0d, got %0d", $time,
				want.most_used_found, got.most_used_found);
			errors++;
		end
	endtask

	always @(posedge clk) begin : monitor
		typed_t  t;
		result_t predicted;
		if (arst_n) begin
			if (cfg_we) count_on = cfg_wdata;
			if (start && !busy) begin
				t = typed_results.pop_front();
				predicted = histogram_apply(cmd);
				pending_results.push_back(t.valid ? t.want : predicted);
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result with nothing expected, expected none, got %p",
						$time, result);
					errors++;
				end else begin
					compare_result(pending_results.pop_front(), result);
				end
			end
		end
	end

	task automatic send(cmd_t c, bit pinned, result_t want);
		typed_t t;
		t.valid = pinned;
		t.want = want;
		typed_results.push_back(t);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	// step past the current edge first so an item taken there is already queued
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_count_enable(bit v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic row_t ev(op_t op, int id);
		row_t r;
		r = '{default: '0};
		r.c.opcode = op;
		r.c.event_id = id[7:0];
		return r;
	endfunction

	function automatic row_t ev_typed(op_t op, int id, bit acc, int bin, int tot, int idx,
			int cnt, bit fnd);
		row_t r;
		r = ev(op, id);
		r.pinned = 1'b1;
		r.want.accepted = acc;
		r.want.bin_count = bin;
		r.want.table_total = tot;
		r.want.most_used_index = idx[7:0];
		r.want.most_used_count = cnt;
		r.want.most_used_found = fnd;
		return r;
	endfunction

	function automatic row_t wr_enable(bit v);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.cfg_val = v;
		return r;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned pick;
		c.opcode = ($urandom_range(99) < 70) ? 2'($urandom_range(1)) : 2'($urandom_range(3, 2));
		pick = $urandom_range(99);
		// a few hot bins give ties and peak changes
		if (pick < 55) c.event_id = 8'($urandom_range(3));
		else if (pick < 85) c.event_id = 8'($urandom_range(c.opcode[0] ? FUNC_BINS - 1 :
			INSTR_BINS - 1));
		else c.event_id = 8'($urandom_range(255));
		return c;
	endfunction

	initial begin : stimulus
		int unsigned idle_pct [5];
		bit          enable_of [5];
		idle_pct = '{0, 83, 0, 37, 0};
		enable_of = '{1, 1, 0, 1, 1};
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;

		// counting off after reset
		script.push_back(ev_typed(OP_READ_INSTR, 0, 1, 0, 0, 0, 0, 0));
		script.push_back(ev_typed(OP_READ_FUNC, 0, 1, 0, 0, 255, 0, 0));
		script.push_back(ev_typed(OP_READ_INSTR, 255, 0, 0, 0, 0, 0, 0));
		script.push_back(ev_typed(OP_READ_FUNC, 16, 0, 0, 0, 255, 0, 0));
		script.push_back(ev_typed(OP_COUNT_INSTR, 5, 0, 0, 0, 0, 0, 0));
		script.push_back(ev_typed(OP_COUNT_FUNC, 15, 0, 0, 0, 255, 0, 0));
		script.push_back(wr_enable(1'b1));
		script.push_back(ev_typed(OP_COUNT_INSTR, 5, 1, 1, 1, 5, 1, 1));
		script.push_back(ev_typed(OP_COUNT_INSTR, 63, 1, 1, 2, 5, 1, 1));
		script.push_back(ev_typed(OP_COUNT_INSTR, 64, 0, 0, 2, 5, 1, 1));
		script.push_back(ev(OP_COUNT_INSTR, 63));
		script.push_back(ev(OP_COUNT_INSTR, 5));
		script.push_back(ev_typed(OP_COUNT_FUNC, 15, 1, 1, 1, 15, 1, 1));
		script.push_back(ev(OP_COUNT_FUNC, 0));
		script.push_back(ev(OP_COUNT_FUNC, 255));
		script.push_back(ev(OP_COUNT_FUNC, 16));
		script.push_back(ev(OP_READ_FUNC, 15));
		script.push_back(ev(OP_READ_INSTR, 63));
		script.push_back(ev(OP_COUNT_INSTR, 0));
		script.push_back(ev(OP_COUNT_INSTR, 8'hAA));
		script.push_back(ev(OP_READ_FUNC, 8'h55));
		script.push_back(ev(OP_READ_INSTR, 8'h2A));
		script.push_back(ev(OP_READ_INSTR, 8'h15));
		// disabled count still reports the bin
		script.push_back(wr_enable(1'b0));
		script.push_back(ev(OP_COUNT_INSTR, 5));
		script.push_back(ev(OP_COUNT_FUNC, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].is_cfg) set_count_enable(script[i].cfg_val);
			else send(script[i].c, script[i].pinned, script[i].want);
		end

		for (int p = 0; p < 5; p++) begin
			set_count_enable(enable_of[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				while ($urandom_range(99) < idle_pct[p]) begin
					start <= 1'b0;
					@(posedge clk);
				end
				if (p == 1 && n == PHASE_ITEMS / 2) drain();
				send(random_cmd(), 1'b0, '0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin : watchdog
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
